// ----- hw/rtl/tbrl_pkg.sv -----
// ----------------------------------------------------------------------------
// Token bucket rate limiter package
// Shared constants, register indexes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package tbrl_pkg;

    localparam int BUCKETS_DEF    = 256;
    localparam int TOKEN_BITS_DEF = 16;

    localparam int TIME_W     = 32;
    localparam int RATE_W     = 16;
    localparam int CAP_W      = 16;
    localparam int OUT_TOK_W  = 16;
    localparam int IDX_IN_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE = 1'b1;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 16'd10;
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;   // write one cleared entry during the post-reset pass
        logic load;    // request accepted, issue the bucket read
        logic calc1;   // refill product, stamp and retry-after
        logic calc2;   // saturate, decide, write back, load the result
    } tbrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;   // last entry of the clearing pass is being written
        logic out_stall;  // result register full and not being taken
    } tbrl_stat_t;

endpackage

// ----- hw/rtl/tbrl_if.sv -----
// ----------------------------------------------------------------------------
// Token bucket rate limiter channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tbrl_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  bucket_index;
    logic [31:0] now_seconds;

    modport source (output valid, output bucket_index, output now_seconds, input ready);
    modport sink   (input valid, input bucket_index, input now_seconds, output ready);
endinterface

interface tbrl_rsp_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic [15:0] remaining;
    logic [31:0] reset_time;
    logic [31:0] retry_wait;

    modport source (output valid, output allowed, output remaining, output reset_time,
                    output retry_wait, input ready);
    modport sink   (input valid, input allowed, input remaining, input reset_time,
                    input retry_wait, output ready);
endinterface

// ----- hw/rtl/tbrl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Token bucket rate limiter controller
// Sequences the clearing pass and the read, compute and write-back steps.
// ----------------------------------------------------------------------------
module tbrl_ctrl
    import tbrl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tbrl_stat_t stat,
    output tbrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC1,
        ST_CALC2
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        cmd.clear = (state_reg == ST_CLEAR);
        cmd.load  = (state_reg == ST_IDLE) && in_valid && ready_reg;
        cmd.calc1 = (state_reg == ST_CALC1);
        cmd.calc2 = (state_reg == ST_CALC2) && !stat.out_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_CALC1;
                    ready_next = 1'b0;
                end
            end
            ST_CALC1:
            begin
                state_next = ST_CALC2;
            end
            ST_CALC2:
            begin
                if (!stat.out_stall)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

// ----- hw/rtl/tbrl_datapath.sv -----
// ----------------------------------------------------------------------------
// Token bucket rate limiter datapath
// Configuration registers, bucket memory, refill arithmetic and result register.
// ----------------------------------------------------------------------------
module tbrl_datapath
    import tbrl_pkg::*;
#(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int TOKEN_BITS = TOKEN_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tbrl_cmd_t             cmd,
    output tbrl_stat_t            stat,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IDX_IN_W-1:0]   in_bucket_index,
    input  logic [TIME_W-1:0]     in_now_seconds,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_allowed,
    output logic [OUT_TOK_W-1:0]  out_remaining,
    output logic [TIME_W-1:0]     out_reset_time,
    output logic [TIME_W-1:0]     out_retry_wait
);

    localparam int IDX_W = $clog2(BUCKETS);
    localparam int TB    = TOKEN_BITS;
    localparam int ENT_W = 1 + TB + TIME_W;
    localparam int PROD_W = RATE_W + TIME_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [32:0] TMAX = (33'd1 << TOKEN_BITS) - 33'd1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);

    // Configuration registers.
    logic [CAP_W-1:0]  cap_reg;
    logic [RATE_W-1:0] rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RESET;
            rate_reg <= RATE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CAPACITY:    cap_reg  <= CAP_W'(cfg_wdata);
                REG_REFILL_RATE: rate_reg <= RATE_W'(cfg_wdata);
                default:         ;
            endcase
        end
    end

    // Effective capacity is the register clipped to what a bucket can hold.
    logic [32:0]   cap33;
    logic [TB-1:0] cap_eff;

    assign cap33   = 33'(cap_reg);
    assign cap_eff = TB'((cap33 < TMAX) ? cap33 : TMAX);

    // Bucket index folded into the table depth.
    logic [IDX_W-1:0] in_idx;

    generate
        if (BUCKETS >= 256)
        begin : g_idx_direct
            assign in_idx = IDX_W'(in_bucket_index);
        end
        else
        begin : g_idx_fold
            logic [IDX_W-1:0] fold_tab [256];
            for (genvar g = 0; g < 256; g++)
            begin : g_tab
                assign fold_tab[g] = IDX_W'(g % BUCKETS);
            end
            assign in_idx = fold_tab[in_bucket_index];
        end
    endgenerate

    // Clearing pass address.
    logic [IDX_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
    end

    assign stat.clr_done = cmd.clear && (clr_cnt_reg == LAST_IDX);

    // Bucket memory: {valid, tokens, stamp}.
    logic [ENT_W-1:0] mem [BUCKETS];
    logic [ENT_W-1:0] rd_reg;
    logic [ENT_W-1:0] wr_data;
    logic [IDX_W-1:0] idx_reg;
    logic [TIME_W-1:0] now_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.calc2)
        begin
            mem[idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_reg  <= mem[in_idx];
            idx_reg <= in_idx;
            now_reg <= in_now_seconds;
        end
    end

    // First compute step: initial fill, elapsed time, refill product.
    logic              rd_valid;
    logic [TB-1:0]     base_tok;
    logic [TIME_W-1:0] base_stamp;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] new_stamp;
    logic [TIME_W-1:0] next_stamp;
    logic [PROD_W-1:0] prod;

    assign rd_valid   = rd_reg[ENT_W-1];
    assign base_tok   = rd_valid ? rd_reg[TIME_W +: TB] : cap_eff;
    assign base_stamp = rd_valid ? rd_reg[TIME_W-1:0] : now_reg;
    assign elapsed    = (now_reg > base_stamp) ? (now_reg - base_stamp) : '0;
    assign new_stamp  = (elapsed != '0) ? now_reg : base_stamp;
    assign next_stamp = new_stamp + TIME_W'(1);
    assign prod       = PROD_W'(rate_reg) * PROD_W'(elapsed);

    logic [TB-1:0]     tok_reg;
    logic [TIME_W-1:0] stamp_reg;
    logic [TIME_W-1:0] new_stamp_reg;
    logic [TIME_W-1:0] next_reg;
    logic [TIME_W-1:0] retry_reg;
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.calc1)
        begin
            tok_reg       <= base_tok;
            stamp_reg     <= base_stamp;
            new_stamp_reg <= new_stamp;
            next_reg      <= next_stamp;
            retry_reg     <= (next_stamp > now_reg) ? (next_stamp - now_reg) : '0;
            prod_reg      <= prod;
        end
    end

    // Second compute step: saturate, take a token, write back.
    logic [SUM_W-1:0] sum;
    logic [TB-1:0]    sat;
    logic             grant;
    logic [TB-1:0]    left;

    assign sum   = SUM_W'(tok_reg) + SUM_W'(prod_reg);
    assign sat   = (sum > SUM_W'(cap_eff)) ? cap_eff : TB'(sum);
    assign grant = (sat != '0);
    assign left  = sat - TB'(1);

    // A denied request leaves the bucket as it was, but a new bucket is still
    // marked valid with its initial fill and stamp.
    assign wr_data = grant ? {1'b1, left, new_stamp_reg} : {1'b1, tok_reg, stamp_reg};

    // Result register.
    logic                 out_valid_reg;
    logic                 allowed_reg;
    logic [OUT_TOK_W-1:0] remaining_reg;
    logic [TIME_W-1:0]    reset_time_reg;
    logic [TIME_W-1:0]    retry_wait_reg;

    assign stat.out_stall = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.calc2)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc2)
        begin
            allowed_reg    <= grant;
            remaining_reg  <= grant ? OUT_TOK_W'(left) : '0;
            reset_time_reg <= next_reg;
            retry_wait_reg <= grant ? '0 : retry_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_allowed    = allowed_reg;
    assign out_remaining  = remaining_reg;
    assign out_reset_time = reset_time_reg;
    assign out_retry_wait = retry_wait_reg;

endmodule

// ----- hw/rtl/token_bucket_rate_limiter.sv -----
// ----------------------------------------------------------------------------
// Token bucket rate limiter
// Per-bucket token bucket policer with refill over elapsed seconds.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel with a bucket index and the current time
// in whole seconds; each request produces exactly one response on the rsp
// channel saying whether it was admitted, the tokens left, the reset time and
// the retry-after time for a rejected request.
// The capacity and refill rate come in on the plain cfg write port; the user
// must write them only while no request is in flight; the block does not check it.
// After reset the block runs a clearing pass over the bucket memory, one entry
// per cycle, so req.ready stays low until the last entry has been cleared.
// An accepted request goes through the CALC1 and CALC2 steps, and its response is
// loaded into the output register as CALC2 writes the bucket entry back. The block
// takes no new request until the last one has been written back.
// The response sits in an output register; while the receiver stalls, the
// block still takes one more request and holds it just before write-back until
// the output register frees up.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter
    import tbrl_pkg::*;
#(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int TOKEN_BITS = TOKEN_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tbrl_req_if.sink              req,
    tbrl_rsp_if.source            rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Commands and status between the sequencer and the arithmetic.
    tbrl_cmd_t  cmd;
    tbrl_stat_t stat;

    // The controller owns the request handshake and the order of the steps.
    tbrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the registers, the bucket memory and the result.
    tbrl_datapath #(
        .BUCKETS    (BUCKETS),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_bucket_index (req.bucket_index),
        .in_now_seconds  (req.now_seconds),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_allowed     (rsp.allowed),
        .out_remaining   (rsp.remaining),
        .out_reset_time  (rsp.reset_time),
        .out_retry_wait  (rsp.retry_wait)
    );

endmodule

// ----- hw/rtl/tbrl_checker.sv -----
// ----------------------------------------------------------------------------
// Token bucket rate limiter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tbrl_checker
    import tbrl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic                 rsp_allowed,
    input logic [OUT_TOK_W-1:0] rsp_remaining,
    input logic [TIME_W-1:0]    rsp_retry_wait
);

    // A pending response is not withdrawn.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // An admitted request has nothing to wait for.
    a_admit_no_retry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_allowed |-> rsp_retry_wait == '0)
        else $error("admitted response carries retry-after");

    // A rejected request leaves no tokens.
    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_allowed |-> rsp_remaining == '0)
        else $error("rejected response reports tokens");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_allowed    (rsp.allowed),
    .rsp_remaining  (rsp.remaining),
    .rsp_retry_wait (rsp.retry_wait)
);
